[hdl/u16alu_pkg.sv]
`timescale 1ns / 1ps

package u16alu_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned DivSteps = 16;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_MAD  = 5'd3,
        OP_SAD  = 5'd4,
        OP_DIV  = 5'd5,
        OP_REM  = 5'd6,
        OP_MIN  = 5'd7,
        OP_MAX  = 5'd8,
        OP_CVT  = 5'd9,
        OP_AND  = 5'd10,
        OP_OR   = 5'd11,
        OP_SHL  = 5'd12,
        OP_SHR  = 5'd13,
        OP_SELP = 5'd14,
        OP_SETP = 5'd15
    } opcode_t;

    localparam logic [2:0] MOD_HI   = 3'd0;
    localparam logic [2:0] MOD_LO   = 3'd1;
    localparam logic [2:0] MOD_WIDE = 3'd2;

    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_LE = 3'd3;
    localparam logic [2:0] CMP_GT = 3'd4;
    localparam logic [2:0] CMP_GE = 3'd5;

    localparam logic [3:0] TY_U8   = 4'd0;
    localparam logic [3:0] TY_U16  = 4'd1;
    localparam logic [3:0] TY_U32  = 4'd2;
    localparam logic [3:0] TY_S8   = 4'd4;
    localparam logic [3:0] TY_S16  = 4'd5;
    localparam logic [3:0] TY_PRED = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADMOD = 2'd1;
    localparam logic [1:0] ST_UNIMPL = 2'd2;

    // unit that finishes an instruction in the back end
    typedef enum logic [1:0] {
        UNIT_SIMPLE = 2'd0,
        UNIT_MUL    = 2'd1,
        UNIT_DIV    = 2'd2
    } unit_t;

    // decoded instruction handed from front to back
    typedef struct packed {
        unit_t       unit;
        logic        is_mad;
        logic        is_rem;
        logic [2:0]  modifier;
        logic [15:0] src_a;
        logic [15:0] src_b;
        logic [15:0] src_c;
        logic [63:0] result;
        logic [3:0]  result_type;
        logic [1:0]  status;
    } uop_t;

    // divider stage word
    typedef struct packed {
        logic        valid;
        uop_t        uop;
        logic [15:0] quot;
        logic [16:0] rem;
    } div_stage_t;

    typedef struct packed {
        logic [63:0] result;
        logic [3:0]  result_type;
        logic [1:0]  status;
    } res_t;

endpackage

[hdl/unsigned16_instruction_alu.sv]
`timescale 1ns / 1ps

// Channel | Dir | Signals                    | Payload
// s_axis  | in  | tvalid tready tdata[95:0]  | kind, modifier, a, b, c, shift_count
// m_axis  | out | tvalid tready tdata[71:0]  | result, result_type, status
//
// One instruction per cycle unless m_axis stalls; the path is the decode register,
// a two-entry queue and an 18-stage back pipe set by the one-bit-per-stage divider.
// Reset clears all valid state; no clearing pass.
// An output stall freezes the back pipe; the queue then lets the front take
// up to three more instructions before s_axis_tready drops.
module unsigned16_instruction_alu
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[4:0], modifier[7:5], src_a[23:8], src_b[39:24], src_c[55:40],
    // shift_count[87:56], zero[95:88]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[63:0], result_type[67:64], status[69:68], zero[71:70]
    output logic [71:0] m_axis_tdata
);

    u16alu_pkg::uop_t f_uop;
    u16alu_pkg::uop_t q_uop;
    u16alu_pkg::res_t res;
    logic             f_valid;
    logic             f_ready;
    logic             q_valid;
    logic             q_ready;

    u16alu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .kind        (s_axis_tdata[4:0]),
        .modifier    (s_axis_tdata[7:5]),
        .src_a       (s_axis_tdata[23:8]),
        .src_b       (s_axis_tdata[39:24]),
        .src_c       (s_axis_tdata[55:40]),
        .shift_count (s_axis_tdata[87:56]),
        .uop_valid   (f_valid),
        .uop_ready   (f_ready),
        .uop         (f_uop)
    );

    u16alu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_uop),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_uop)
    );

    u16alu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (q_valid),
        .uop_ready (q_ready),
        .uop       (q_uop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.status, res.result_type, res.result};

endmodule

[hdl/u16alu_front.sv]
`timescale 1ns / 1ps

module u16alu_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [4:0]             kind,
    input  logic [2:0]             modifier,
    input  logic [15:0]            src_a,
    input  logic [15:0]            src_b,
    input  logic [15:0]            src_c,
    input  logic [31:0]            shift_count,
    output logic                   uop_valid,
    input  logic                   uop_ready,
    output u16alu_pkg::uop_t       uop
);

    u16alu_pkg::uop_t dec;
    u16alu_pkg::uop_t uop_reg;
    logic             valid_reg;
    logic             a_lt_b;
    logic             pred;
    logic [15:0]      absdiff;

    assign a_lt_b  = src_a < src_b;
    assign absdiff = a_lt_b ? (src_b - src_a) : (src_a - src_b);

    // setp compare
    always_comb
    begin
        case (modifier)
            u16alu_pkg::CMP_EQ: pred = src_a == src_b;
            u16alu_pkg::CMP_NE: pred = src_a != src_b;
            u16alu_pkg::CMP_LT: pred = a_lt_b;
            u16alu_pkg::CMP_LE: pred = src_a <= src_b;
            u16alu_pkg::CMP_GT: pred = src_a > src_b;
            u16alu_pkg::CMP_GE: pred = !a_lt_b;
            default:            pred = 1'b0;
        endcase
    end

    // classify and finish the simple operations
    always_comb
    begin
        dec             = '0;
        dec.unit        = u16alu_pkg::UNIT_SIMPLE;
        dec.modifier    = modifier;
        dec.src_a       = src_a;
        dec.src_b       = src_b;
        dec.src_c       = src_c;
        dec.result_type = u16alu_pkg::TY_U16;
        dec.status      = u16alu_pkg::ST_OK;
        case (kind)
            u16alu_pkg::OP_ADD: dec.result = {48'd0, src_a + src_b};
            u16alu_pkg::OP_SUB: dec.result = {48'd0, src_a - src_b};
            u16alu_pkg::OP_MUL, u16alu_pkg::OP_MAD:
            begin
                dec.is_mad = kind == u16alu_pkg::OP_MAD;
                if (modifier > u16alu_pkg::MOD_WIDE)
                begin
                    dec.status = u16alu_pkg::ST_BADMOD;
                end
                else
                begin
                    dec.unit = u16alu_pkg::UNIT_MUL;
                end
            end
            u16alu_pkg::OP_SAD: dec.result = {48'd0, absdiff + src_c};
            u16alu_pkg::OP_DIV, u16alu_pkg::OP_REM:
            begin
                dec.unit   = u16alu_pkg::UNIT_DIV;
                dec.is_rem = kind == u16alu_pkg::OP_REM;
            end
            u16alu_pkg::OP_MIN: dec.result = {48'd0, a_lt_b ? src_a : src_b};
            u16alu_pkg::OP_MAX: dec.result = {48'd0, (src_a > src_b) ? src_a : src_b};
            u16alu_pkg::OP_CVT:
            begin
                dec.result_type = {1'b0, modifier};
                case ({1'b0, modifier})
                    u16alu_pkg::TY_U8:  dec.result = {56'd0, src_a[7:0]};
                    u16alu_pkg::TY_S8:  dec.result = {{56{src_a[7]}}, src_a[7:0]};
                    u16alu_pkg::TY_S16: dec.result = {{48{src_a[15]}}, src_a};
                    default:            dec.result = {48'd0, src_a};
                endcase
            end
            u16alu_pkg::OP_AND: dec.result = {48'd0, src_a & src_b};
            u16alu_pkg::OP_OR:  dec.result = {48'd0, src_a | src_b};
            u16alu_pkg::OP_SHL:
                dec.result = (src_b[15:4] != 12'd0) ? 64'd0 : {48'd0, src_a << src_b[3:0]};
            u16alu_pkg::OP_SHR:
                dec.result = (shift_count[31:4] != 28'd0) ? 64'd0
                           : {48'd0, src_a >> shift_count[3:0]};
            u16alu_pkg::OP_SELP: dec.result = {48'd0, (src_c != 16'd0) ? src_a : src_b};
            u16alu_pkg::OP_SETP:
            begin
                if (modifier > u16alu_pkg::CMP_GE)
                begin
                    dec.status = u16alu_pkg::ST_BADMOD;
                end
                else
                begin
                    dec.result      = {63'd0, pred};
                    dec.result_type = u16alu_pkg::TY_PRED;
                end
            end
            default: dec.status = u16alu_pkg::ST_UNIMPL;
        endcase
        if (dec.status != u16alu_pkg::ST_OK)
        begin
            dec.result      = '0;
            dec.result_type = '0;
        end
    end

    assign in_ready  = !valid_reg || uop_ready;
    assign uop_valid = valid_reg;
    assign uop       = uop_reg;

    // decode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            uop_reg <= dec;
        end
    end

endmodule

[hdl/u16alu_queue.sv]
`timescale 1ns / 1ps

module u16alu_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  u16alu_pkg::uop_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output u16alu_pkg::uop_t rd_data
);

    u16alu_pkg::uop_t mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !do_wr)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> !do_rd)
        else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count slip");

endmodule

[hdl/u16alu_back.sv]
`timescale 1ns / 1ps

module u16alu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             uop_valid,
    output logic             uop_ready,
    input  u16alu_pkg::uop_t uop,
    output logic             out_valid,
    input  logic             out_ready,
    output u16alu_pkg::res_t out_res
);

    localparam int unsigned NStages = u16alu_pkg::DivSteps + 2;

    // pipe: stage 0 = issue/multiply, 1..16 = divider steps, 17 = output
    u16alu_pkg::div_stage_t st_reg [NStages];
    u16alu_pkg::div_stage_t st_next [NStages];
    logic [31:0]            prod_reg;
    logic [31:0]            prod_next;
    logic                   advance;

    // whole pipe moves together when the tail slot is empty or its result is taken
    assign advance   = !st_reg[NStages-1].valid || out_ready;
    assign uop_ready = advance;
    assign out_valid = st_reg[NStages-1].valid;

    always_comb
    begin
        u16alu_pkg::div_stage_t s;
        logic [16:0] trial;
        logic [16:0] diff;
        logic [31:0] wide;
        logic [15:0] narrow;
        s = '0;
        trial = '0;
        diff = '0;
        wide = '0;
        narrow = '0;
        st_next[0]       = '0;
        st_next[0].valid = uop_valid;
        st_next[0].uop   = uop;
        prod_next        = uop.src_a * uop.src_b;
        // restoring divider, one quotient bit per stage
        for (int i = 1; i <= int'(u16alu_pkg::DivSteps); i++)
        begin
            s = st_reg[i-1];
            if (i == 1)
            begin
                s.quot = s.uop.src_a;
                s.rem  = '0;
            end
            trial = {s.rem[15:0], s.quot[15]};
            diff  = trial - {1'b0, s.uop.src_b};
            if (!diff[16])
            begin
                s.rem  = diff;
                s.quot = {s.quot[14:0], 1'b1};
            end
            else
            begin
                s.rem  = trial;
                s.quot = {s.quot[14:0], 1'b0};
            end
            st_next[i] = s;
        end
        // finish: multiply, divide or pass-through
        s = st_reg[NStages-2];
        case (s.uop.unit)
            u16alu_pkg::UNIT_DIV:
            begin
                if (s.uop.src_b == 16'd0)
                begin
                    s.uop.result = {48'd0, 16'hFFFF};
                end
                else
                begin
                    s.uop.result = {48'd0, s.uop.is_rem ? s.rem[15:0] : s.quot};
                end
            end
            u16alu_pkg::UNIT_MUL:
            begin
                wide   = {s.rem[15:0], s.quot};
                narrow = (s.uop.modifier == u16alu_pkg::MOD_HI) ? wide[31:16] : wide[15:0];
                if (s.uop.modifier == u16alu_pkg::MOD_WIDE)
                begin
                    s.uop.result      = {32'd0, wide + (s.uop.is_mad ? {16'd0, s.uop.src_c} : 32'd0)};
                    s.uop.result_type = u16alu_pkg::TY_U32;
                end
                else
                begin
                    s.uop.result = {48'd0, narrow + (s.uop.is_mad ? s.uop.src_c : 16'd0)};
                end
            end
            default: ;
        endcase
        st_next[NStages-1] = s;
    end

    // pipeline registers; the product rides in the divider fields of mul items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            for (int i = 0; i < int'(NStages); i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            prod_reg  <= prod_next;
            st_reg[0] <= st_next[0];
            for (int i = 1; i < int'(NStages); i++)
            begin
                st_reg[i].valid <= st_next[i].valid;
                st_reg[i].uop   <= st_next[i].uop;
                if (st_next[i].uop.unit != u16alu_pkg::UNIT_DIV)
                begin
                    // hold the product from stage 1 onward
                    if (i == 1)
                    begin
                        st_reg[i].quot <= prod_reg[15:0];
                        st_reg[i].rem  <= {1'b0, prod_reg[31:16]};
                    end
                    else
                    begin
                        st_reg[i].quot <= st_reg[i-1].quot;
                        st_reg[i].rem  <= st_reg[i-1].rem;
                    end
                end
                else
                begin
                    st_reg[i].quot <= st_next[i].quot;
                    st_reg[i].rem  <= st_next[i].rem;
                end
            end
        end
    end

    assign out_res.result      = st_reg[NStages-1].uop.result;
    assign out_res.result_type = st_reg[NStages-1].uop.result_type;
    assign out_res.status      = st_reg[NStages-1].uop.status;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.status != u16alu_pkg::ST_OK |-> out_res.result == 64'd0)
        else $error("failed op wrote data");
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg[0].valid))
        else $error("pipe moved under stall");

endmodule

[verif/unsigned16_instruction_alu_tb.sv]
`timescale 1ns / 1ps

module unsigned16_instruction_alu_tb;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned RandomCount = 1350;
    localparam logic [3:0] TY_NONE = 4'd0;

    // one instruction as driven on s_axis
    typedef struct packed {
        logic [31:0] shift_count;
        logic [15:0] src_c;
        logic [15:0] src_b;
        logic [15:0] src_a;
        logic [2:0]  modifier;
        logic [4:0]  kind;
    } instr_t;

    // pending results in issue order, checked against m_axis transfers
    class alu_scoreboard;
        u16alu_pkg::res_t pending[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        // compute the outcome of one instruction
        function u16alu_pkg::res_t execute(instr_t ins);
            u16alu_pkg::res_t r;
            logic [31:0]      prod;
            logic [15:0]      a;
            logic [15:0]      b;
            logic [15:0]      c;
            logic [15:0]      addend;
            logic             pred;
            a = ins.src_a;
            b = ins.src_b;
            c = ins.src_c;
            prod = 32'(a) * 32'(b);
            r.result = '0;
            r.result_type = u16alu_pkg::TY_U16;
            r.status = u16alu_pkg::ST_OK;
            pred = 1'b0;
            case (ins.kind)
                u16alu_pkg::OP_ADD: r.result = 64'(16'(a + b));
                u16alu_pkg::OP_SUB: r.result = 64'(16'(a - b));
                u16alu_pkg::OP_MUL, u16alu_pkg::OP_MAD:
                begin
                    addend = (ins.kind == u16alu_pkg::OP_MAD) ? c : 16'd0;
                    case (ins.modifier)
                        u16alu_pkg::MOD_HI:   r.result = 64'(16'(prod[31:16] + addend));
                        u16alu_pkg::MOD_LO:   r.result = 64'(16'(prod[15:0] + addend));
                        u16alu_pkg::MOD_WIDE:
                        begin
                            r.result = 64'(prod) + 64'(addend);
                            r.result_type = u16alu_pkg::TY_U32;
                        end
                        default:  r.status = u16alu_pkg::ST_BADMOD;
                    endcase
                end
                u16alu_pkg::OP_SAD: r.result = 64'(16'(((a < b) ? b - a : a - b) + c));
                u16alu_pkg::OP_DIV: r.result = (b == 0) ? 64'hFFFF : 64'(a / b);
                u16alu_pkg::OP_REM: r.result = (b == 0) ? 64'hFFFF : 64'(a % b);
                u16alu_pkg::OP_MIN: r.result = 64'((a < b) ? a : b);
                u16alu_pkg::OP_MAX: r.result = 64'((a > b) ? a : b);
                u16alu_pkg::OP_CVT:
                begin
                    r.result_type = 4'(ins.modifier);
                    case (4'(ins.modifier))
                        u16alu_pkg::TY_U8:  r.result = 64'(a[7:0]);
                        u16alu_pkg::TY_S8:  r.result = {{56{a[7]}}, a[7:0]};
                        u16alu_pkg::TY_S16: r.result = {{48{a[15]}}, a};
                        default:            r.result = 64'(a);
                    endcase
                end
                u16alu_pkg::OP_AND: r.result = 64'(a & b);
                u16alu_pkg::OP_OR:  r.result = 64'(a | b);
                u16alu_pkg::OP_SHL: r.result = (b >= 16) ? 64'd0 : 64'(16'(a << b[3:0]));
                u16alu_pkg::OP_SHR: r.result = (ins.shift_count >= 16) ? 64'd0
                                             : 64'(a >> ins.shift_count[3:0]);
                u16alu_pkg::OP_SELP: r.result = 64'((c != 0) ? a : b);
                u16alu_pkg::OP_SETP:
                begin
                    case (ins.modifier)
                        u16alu_pkg::CMP_EQ: pred = (a == b);
                        u16alu_pkg::CMP_NE: pred = (a != b);
                        u16alu_pkg::CMP_LT: pred = (a < b);
                        u16alu_pkg::CMP_LE: pred = (a <= b);
                        u16alu_pkg::CMP_GT: pred = (a > b);
                        u16alu_pkg::CMP_GE: pred = (a >= b);
                        default:            r.status = u16alu_pkg::ST_BADMOD;
                    endcase
                    r.result = 64'(pred);
                    r.result_type = u16alu_pkg::TY_PRED;
                end
                default: r.status = u16alu_pkg::ST_UNIMPL;
            endcase
            if (r.status != u16alu_pkg::ST_OK)
            begin
                r.result = '0;
                r.result_type = TY_NONE;
            end
            return r;
        endfunction

        function void note_issue(instr_t ins);
            pending.push_back(execute(ins));
        endfunction

        function void check_result(logic [71:0] data);
            u16alu_pkg::res_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer %h", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[63:0] !== want.result)
            begin
                $error("result: expected %h, got %h", want.result, data[63:0]);
                errors++;
            end
            if (data[67:64] !== want.result_type)
            begin
                $error("result_type: expected %0d, got %0d",
                       want.result_type, data[67:64]);
                errors++;
            end
            if (data[69:68] !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, data[69:68]);
                errors++;
            end
            if (data[71:70] !== 2'b00)
            begin
                $error("pad: expected 0, got %b", data[71:70]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    alu_scoreboard sb;
    bit            stim_done;
    bit            long_hold;
    int unsigned   cycle_count;

    unsigned16_instruction_alu uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // offer one instruction, hold until transfer; valid stays high afterwards
    task automatic send_instr(instr_t ins);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {8'd0, ins};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_issue(ins);
        @(negedge clk);
    endtask

    task automatic idle_gap(int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'(1 << $urandom_range(0, 15));
            3: return 16'($urandom_range(0, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        ins.kind = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                                : 5'($urandom_range(0, 15));
        ins.modifier = 3'($urandom);
        ins.src_a = pick16();
        ins.src_b = pick16();
        ins.src_c = pick16();
        case ($urandom_range(0, 3))
            0: ins.shift_count = 32'($urandom_range(0, 20));
            1: ins.shift_count = $urandom;
            default: ins.shift_count = 32'($urandom_range(0, 15));
        endcase
        if (ins.kind == u16alu_pkg::OP_SHL && $urandom_range(0, 1))
            ins.src_b = 16'($urandom_range(0, 18));
        return ins;
    endfunction

    function automatic instr_t mk(logic [4:0] k, logic [2:0] m, logic [15:0] a,
                                  logic [15:0] b, logic [15:0] c, logic [31:0] s);
        instr_t ins;
        ins.kind = k;
        ins.modifier = m;
        ins.src_a = a;
        ins.src_b = b;
        ins.src_c = c;
        ins.shift_count = s;
        return ins;
    endfunction

    // stimulus
    initial
    begin
        instr_t dir[$];
        int unsigned burst;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        stim_done = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners: every opcode, div by zero, long shifts, bad modifiers
        dir.push_back(mk(u16alu_pkg::OP_ADD, 0, 16'hFFFF, 16'hFFFF, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_SUB, 0, 16'd0, 16'd1, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_MUL, u16alu_pkg::MOD_HI, 16'hFFFF, 16'hFFFF, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_MUL, u16alu_pkg::MOD_LO, 16'hFFFF, 16'hFFFF, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_MAD, u16alu_pkg::MOD_WIDE, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 0));
        dir.push_back(mk(u16alu_pkg::OP_MAD, u16alu_pkg::MOD_HI, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 0));
        dir.push_back(mk(u16alu_pkg::OP_MUL, 3'd7, 16'd3, 16'd4, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_SAD, 0, 16'd0, 16'hFFFF, 16'hFFFF, 0));
        dir.push_back(mk(u16alu_pkg::OP_DIV, 0, 16'd1234, 16'd0, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_REM, 0, 16'hFFFF, 16'd0, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_DIV, 0, 16'hFFFF, 16'd7, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_REM, 0, 16'hFFFF, 16'd7, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_MIN, 0, 16'd5, 16'hFFFF, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_MAX, 0, 16'd5, 16'hFFFF, 0, 0));
        for (int t = 0; t < 8; t++)
            dir.push_back(mk(u16alu_pkg::OP_CVT, 3'(t), 16'h8080, 0, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_AND, 0, 16'hF0F0, 16'hFFFF, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_OR, 0, 16'hF0F0, 16'h0F0F, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_SHL, 0, 16'hFFFF, 16'd16, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_SHR, 0, 16'hFFFF, 0, 0, 32'hFFFF_FFFF));
        dir.push_back(mk(u16alu_pkg::OP_SELP, 0, 16'd1, 16'd2, 16'h8000, 0));
        dir.push_back(mk(u16alu_pkg::OP_SETP, u16alu_pkg::CMP_GE, 16'hFFFF, 16'hFFFF, 0, 0));
        dir.push_back(mk(u16alu_pkg::OP_SETP, 3'd6, 16'd1, 16'd1, 0, 0));
        dir.push_back(mk(5'd31, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        foreach (dir[i])
            send_instr(dir[i]);

        // random traffic in bursts
        burst = 0;
        for (int n = 0; n < RandomCount; n++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 6));
                burst = $urandom_range(1, 40);
            end
            send_instr(random_instr());
            burst--;
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: patterned stalls plus one long hold-off
    initial
    begin
        int unsigned phase;
        m_axis_tready = 1'b0;
        long_hold = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (phase == 600)
                long_hold = 1'b1;
            if (phase == 800)
                long_hold = 1'b0;
            if (long_hold)
                m_axis_tready <= 1'b0;
            else if ((phase / 128) % 3 == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // end of test and timeout
    initial
    begin
        cycle_count = 0;
        fork
            begin
                wait (stim_done);
                while (sb.pending.size() != 0)
                    @(posedge clk);
                repeat (40) @(posedge clk);
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("== PASS ==");
                else
                    $display("== FAIL ==");
            end
            begin
                while (cycle_count < CycleLimit)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                $error("timeout after %0d cycles", cycle_count);
                $display("== FAIL ==");
            end
        join_any
        $finish;
    end

endmodule

[unsigned16_instruction_alu.f]
hdl/u16alu_pkg.sv
hdl/u16alu_front.sv
hdl/u16alu_queue.sv
hdl/u16alu_back.sv
hdl/unsigned16_instruction_alu.sv
verif/unsigned16_instruction_alu_tb.sv
